/* hw/rtl/rapc_pkg.sv */
// shared types, constants and helpers for the antenna phase correction unit
`default_nettype none
package rapc_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_OFS = 2'd0,
    MODE_LOAD_VAR = 2'd1,
    MODE_COMPUTE  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODEL_ENABLE = 3'd0,
    CFG_ROVER_EAST   = 3'd1,
    CFG_ROVER_NORTH  = 3'd2,
    CFG_ROVER_UP     = 3'd3,
    CFG_BASE_EAST    = 3'd4,
    CFG_BASE_NORTH   = 3'd5,
    CFG_BASE_UP      = 3'd6
  } cfg_reg_t;

  localparam int ANT_ROVER = 0;
  localparam int ANT_BASE  = 1;

  // sine pipeline depth
  localparam int SIN_LAT = 12;

  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [15:0] QUARTER     = 16'd16384;

  // exact reciprocal multipliers for 32 bit dividends, divisors 110, 72, 42, 20, 6
  localparam logic [32:0] DIV_MAGIC [5] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam int DIV_SHIFT [5] = '{39, 39, 38, 37, 35};

  typedef struct packed {
    logic [1:0]  mode;
    logic        ant;
    logic [2:0]  freq;
    logic [4:0]  entry;
    logic [31:0] value;
    logic [15:0] az;
    logic [15:0] el;
    logic        last;
  } uop_t;

  typedef struct packed {
    logic signed [31:0] saz;
    logic signed [31:0] caz;
    logic signed [31:0] sel;
    logic signed [31:0] cel;
  } trig_t;

  typedef struct packed {
    logic             ant;
    logic [2:0]       freq;
    logic             last;
    logic [2:0][31:0] ofs;
    logic [31:0]      v0;
    logic [31:0]      v1;
    logic [15:0]      frac;
    logic [2:0][31:0] e;
  } tab_t;

  typedef struct packed {
    logic             enable;
    logic [1:0][2:0][31:0] delta;
  } cfg_t;

  typedef struct packed {
    logic        ant;
    logic [2:0]  freq;
    logic [31:0] corr;
    logic        last;
  } res_t;

  // shift right with a half rounded away from zero
  function automatic logic signed [71:0] round_shr(input logic signed [71:0] v,
                                                   input int unsigned sh);
    logic [71:0] mag;
    logic [71:0] r;
    mag = v[71] ? 72'(-v) : 72'(v);
    r = (mag + (72'd1 << (sh - 1))) >> sh;
    return v[71] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/receiver_antenna_phase_correction_unit.sv */
// Receiver antenna phase-centre correction. A compute transaction yields
// NUM_FREQS corrections, one per cycle while the result side does not stall,
// and holds the input while the frequencies are issued; table loads give no
// result. Every issued frequency runs through the four sine pipelines
// (SIN_LAT = 12 stages), one table stage and three arithmetic stages.
// Tables read as written; entries not yet loaded read as garbage. A stall
// on the result side freezes the whole pipeline.
`default_nettype none
module receiver_antenna_phase_correction_unit import rapc_pkg::*; #(
  parameter int NUM_FREQS   = 3,
  parameter int GRID_POINTS = 19
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic        in_antenna,
  input  wire logic [2:0]  in_freq_index,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic signed [31:0] in_table_value,
  input  wire logic [15:0] in_azimuth,
  input  wire logic signed [15:0] in_elevation,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_antenna_out,
  output logic [2:0]       out_freq_out,
  output logic signed [31:0] out_correction,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic       adv, is_cmp, final_issue, issue_vld;
  logic [2:0] cnt_r;
  cfg_t       cfg_r;
  uop_t       uop;
  logic       trig_vld, tab_vld, res_vld;
  uop_t       trig_uop;
  trig_t      trig;
  tab_t       tab;
  res_t       res;

  assign adv         = !res_vld || !out_stall;
  assign is_cmp      = (mode_t'(in_mode) == MODE_COMPUTE);
  assign final_issue = !is_cmp || (cnt_r == 3'(NUM_FREQS - 1));
  assign in_stall    = !adv || !final_issue;
  assign issue_vld   = in_valid && (mode_t'(in_mode) != MODE_NONE);

  always_comb begin
    uop.mode  = in_mode;
    uop.ant   = in_antenna;
    uop.freq  = is_cmp ? cnt_r : in_freq_index;
    uop.entry = in_entry_index;
    uop.value = in_table_value;
    uop.az    = in_azimuth;
    uop.el    = in_elevation;
    uop.last  = is_cmp && final_issue;
  end

  // frequency counter of the compute transaction being issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_valid && adv) begin
      cnt_r <= final_issue ? 3'd0 : 3'(cnt_r + 3'd1);
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MODEL_ENABLE: cfg_r.enable <= cfg_data[0];
        CFG_ROVER_EAST:   cfg_r.delta[ANT_ROVER][0] <= cfg_data;
        CFG_ROVER_NORTH:  cfg_r.delta[ANT_ROVER][1] <= cfg_data;
        CFG_ROVER_UP:     cfg_r.delta[ANT_ROVER][2] <= cfg_data;
        CFG_BASE_EAST:    cfg_r.delta[ANT_BASE][0] <= cfg_data;
        CFG_BASE_NORTH:   cfg_r.delta[ANT_BASE][1] <= cfg_data;
        CFG_BASE_UP:      cfg_r.delta[ANT_BASE][2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rapc_trig u_trig (
    .clk, .rst_n, .en(adv),
    .in_vld(issue_vld), .in_uop(uop),
    .out_vld(trig_vld), .out_uop(trig_uop), .trig
  );

  rapc_tables #(.NUM_FREQS(NUM_FREQS), .GRID_POINTS(GRID_POINTS)) u_tables (
    .clk, .rst_n, .en(adv),
    .in_vld(trig_vld), .uop(trig_uop), .trig,
    .tab_vld, .tab
  );

  rapc_dot u_dot (
    .clk, .rst_n, .en(adv), .cfg(cfg_r),
    .tab_vld, .tab, .res_vld, .res
  );

  assign out_valid       = res_vld;
  assign out_antenna_out = res.ant;
  assign out_freq_out    = res.freq;
  assign out_correction  = res.corr;
  assign out_last        = res.last;

endmodule
`default_nettype wire

/* hw/rtl/rapc_sin.sv */
// pipelined fixed point sine of a binary angle, Q30 result
`default_nettype none
module rapc_sin import rapc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        angle,
  output logic signed [31:0]      sin_val
);

  logic [14:0]        rr;
  logic [30:0]        x_nxt;
  logic [30:0]        x_r   [1:11];
  logic [31:0]        x2_r  [2:11];
  logic               neg_r [1:11];
  logic [31:0]        d_r   [2:11];
  logic [31:0]        q_nxt [5];
  logic [32:0]        t_nxt [5];
  logic [32:0]        y;
  logic signed [31:0] sin_r;

  // fold the angle into the first quadrant
  assign rr    = angle[14] ? 15'(16'd16384 - {2'b00, angle[13:0]}) : {1'b0, angle[13:0]};
  assign x_nxt = 31'((46'(rr) * 46'(HALF_PI_Q30)) >> 14);

  always_comb begin
    logic [64:0] prod;
    logic [30:0] s;
    logic [31:0] mop;
    logic [62:0] m;
    for (int k = 0; k < 5; k++) begin
      prod     = 65'(d_r[2 + 2 * k]) * 65'(DIV_MAGIC[k]);
      q_nxt[k] = 32'(prod >> DIV_SHIFT[k]);
      s        = 31'(33'(Q30_ONE) - 33'(d_r[3 + 2 * k]));
      mop      = (k == 4) ? {1'b0, x_r[3 + 2 * k]} : x2_r[3 + 2 * k];
      m        = 63'(mop) * 63'(s);
      t_nxt[k] = 33'(m >> 30);
    end
    y = (t_nxt[4] > 33'(Q30_ONE)) ? 33'(Q30_ONE) : t_nxt[4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1]   <= x_nxt;
      neg_r[1] <= angle[15];
      for (int st = 2; st <= 11; st++) begin
        x_r[st]   <= x_r[st - 1];
        neg_r[st] <= neg_r[st - 1];
      end
      x2_r[2] <= 32'((62'(x_r[1]) * 62'(x_r[1])) >> 30);
      d_r[2]  <= 32'((62'(x_r[1]) * 62'(x_r[1])) >> 30);
      for (int st = 3; st <= 11; st++) begin
        x2_r[st] <= x2_r[st - 1];
      end
      for (int k = 0; k < 5; k++) begin
        d_r[3 + 2 * k] <= q_nxt[k];
        if (k < 4) begin
          d_r[4 + 2 * k] <= t_nxt[k][31:0];
        end
      end
      sin_r <= neg_r[11] ? -$signed(32'(y)) : $signed(32'(y));
    end
  end

  assign sin_val = sin_r;

endmodule
`default_nettype wire

/* hw/rtl/rapc_trig.sv */
// four sine pipelines with the transaction carried alongside
`default_nettype none
module rapc_trig import rapc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_vld,
  input  wire uop_t in_uop,
  output logic      out_vld,
  output uop_t      out_uop,
  output trig_t     trig
);

  uop_t uop_r [1:SIN_LAT];
  logic vld_r [1:SIN_LAT];

  rapc_sin u_sin_az (.clk, .en, .angle(in_uop.az), .sin_val(trig.saz));
  rapc_sin u_cos_az (.clk, .en, .angle(16'(in_uop.az + QUARTER)), .sin_val(trig.caz));
  rapc_sin u_sin_el (.clk, .en, .angle(in_uop.el), .sin_val(trig.sel));
  rapc_sin u_cos_el (.clk, .en, .angle(16'(in_uop.el + QUARTER)), .sin_val(trig.cel));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 1; st <= SIN_LAT; st++) vld_r[st] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_vld;
      for (int st = 2; st <= SIN_LAT; st++) vld_r[st] <= vld_r[st - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uop_r[1] <= in_uop;
      for (int st = 2; st <= SIN_LAT; st++) uop_r[st] <= uop_r[st - 1];
    end
  end

  assign out_vld = vld_r[SIN_LAT];
  assign out_uop = uop_r[SIN_LAT];

endmodule
`default_nettype wire

/* hw/rtl/rapc_tables.sv */
// offset and variation tables, grid lookup and line-of-sight vector
`default_nettype none
module rapc_tables import rapc_pkg::*; #(
  parameter int NUM_FREQS   = 3,
  parameter int GRID_POINTS = 19
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_vld,
  input  wire uop_t  uop,
  input  wire trig_t trig,
  output logic       tab_vld,
  output tab_t       tab
);

  localparam int ROWS      = 2 * NUM_FREQS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int VAR_DEPTH = ROWS * GRID_POINTS;
  localparam int VA_W      = $clog2(VAR_DEPTH);

  logic [2:0][31:0] ofs_mem [ROWS];
  logic [31:0]      var_mem [VAR_DEPTH];

  logic             we_ofs, we_var, is_cmp;
  logic [ROW_W-1:0] row;
  logic [VA_W-1:0]  wa, ra0, ra1;
  logic signed [17:0] zv;
  logic [22:0]      pos;
  logic [6:0]       idx0, idx1;
  logic [15:0]      frac;
  logic             tab_vld_r;
  tab_t             tab_r;

  always_comb begin
    we_ofs = 1'b0;
    we_var = 1'b0;
    is_cmp = 1'b0;
    unique case (mode_t'(uop.mode))
      MODE_LOAD_OFS: we_ofs = (int'(uop.freq) < NUM_FREQS) && (uop.entry < 5'd3);
      MODE_LOAD_VAR: we_var = (int'(uop.freq) < NUM_FREQS) && (int'(uop.entry) < GRID_POINTS);
      MODE_COMPUTE:  is_cmp = 1'b1;
      default: ;
    endcase
  end

  // zenith grid position, clamped at both ends
  always_comb begin
    zv   = 18'sd16384 - 18'($signed(uop.el));
    pos  = 23'(zv[16:0]) * 23'd72;
    idx0 = pos[22:16];
    idx1 = 7'(pos[22:16] + 7'd1);
    frac = pos[15:0];
    if (zv < 0) begin
      idx0 = '0;
      idx1 = '0;
      frac = '0;
    end else if (int'(pos[22:16]) >= GRID_POINTS - 1) begin
      idx0 = 7'(GRID_POINTS - 1);
      idx1 = 7'(GRID_POINTS - 1);
      frac = '0;
    end
  end

  assign row = ROW_W'(int'(uop.ant) * NUM_FREQS + int'(uop.freq));
  assign wa  = VA_W'(int'(row) * GRID_POINTS + int'(uop.entry));
  assign ra0 = VA_W'(int'(row) * GRID_POINTS + int'(idx0));
  assign ra1 = VA_W'(int'(row) * GRID_POINTS + int'(idx1));

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_vld) begin
        if (we_ofs) ofs_mem[row][uop.entry[1:0]] <= uop.value;
        if (we_var) var_mem[wa] <= uop.value;
        if (is_cmp) begin
          tab_r.ofs <= ofs_mem[row];
          tab_r.v0  <= var_mem[ra0];
          tab_r.v1  <= var_mem[ra1];
        end
      end
      tab_r.ant  <= uop.ant;
      tab_r.freq <= uop.freq;
      tab_r.last <= uop.last;
      tab_r.frac <= frac;
      tab_r.e[0] <= 32'(round_shr(72'(trig.saz) * 72'(trig.cel), 30));
      tab_r.e[1] <= 32'(round_shr(72'(trig.caz) * 72'(trig.cel), 30));
      tab_r.e[2] <= trig.sel;
    end
  end

  // only compute transactions go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r <= 1'b0;
    end else if (en) begin
      tab_vld_r <= in_vld && is_cmp;
    end
  end

  assign tab_vld = tab_vld_r;
  assign tab     = tab_r;

endmodule
`default_nettype wire

/* hw/rtl/rapc_dot.sv */
// offset dot product, variation interpolation and saturation
`default_nettype none
module rapc_dot import rapc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire cfg_t cfg,
  input  wire logic tab_vld,
  input  wire tab_t tab,
  output logic      res_vld,
  output res_t      res
);

  logic               v1_r, v2_r, res_vld_r;
  logic signed [65:0] p_r [3];
  logic signed [65:0] p_nxt [3];
  logic signed [49:0] dvp_r, dvp_nxt;
  logic [31:0]        v0_r;
  logic               en1_r, ant1_r, last1_r, ant2_r, last2_r;
  logic [2:0]         freq1_r, freq2_r;
  logic signed [39:0] acc_r, acc_nxt;
  res_t               res_r;

  always_comb begin
    logic signed [32:0] off;
    logic signed [32:0] dv;
    for (int j = 0; j < 3; j++) begin
      off = 33'($signed(cfg.delta[tab.ant][j]));
      if (cfg.enable) off = off + 33'($signed(tab.ofs[j]));
      p_nxt[j] = 66'(72'(off) * 72'($signed(tab.e[j])));
    end
    dv      = 33'($signed(tab.v1)) - 33'($signed(tab.v0));
    dvp_nxt = 50'(72'(dv) * 72'($signed({1'b0, tab.frac})));
  end

  always_comb begin
    logic signed [71:0] sum;
    logic signed [71:0] varc;
    sum = '0;
    for (int j = 0; j < 3; j++) sum = sum + round_shr(72'(p_r[j]), 30);
    varc = en1_r ? 72'($signed(v0_r)) + round_shr(72'(dvp_r), 16) : '0;
    acc_nxt = 40'(varc - sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) p_r[j] <= p_nxt[j];
      dvp_r   <= dvp_nxt;
      v0_r    <= tab.v0;
      en1_r   <= cfg.enable;
      ant1_r  <= tab.ant;
      freq1_r <= tab.freq;
      last1_r <= tab.last;
      acc_r   <= acc_nxt;
      ant2_r  <= ant1_r;
      freq2_r <= freq1_r;
      last2_r <= last1_r;
      res_r.ant  <= ant2_r;
      res_r.freq <= freq2_r;
      res_r.last <= last2_r;
      if (acc_r > 40'sd2147483647) begin
        res_r.corr <= 32'h7fff_ffff;
      end else if (acc_r < -40'sd2147483648) begin
        res_r.corr <= 32'h8000_0000;
      end else begin
        res_r.corr <= acc_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else if (en) begin
      v1_r      <= tab_vld;
      v2_r      <= v1_r;
      res_vld_r <= v2_r;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule
`default_nettype wire

/* verif/receiver_antenna_phase_correction_unit_test.sv */
// testbench for the antenna phase correction unit: random loads, computes and register phases
`timescale 1ns / 1ps
module receiver_antenna_phase_correction_unit_test;
  import rapc_pkg::*;

  localparam int NF = 3;
  localparam int GP = 19;
  localparam longint CYCLE_LIMIT = 400000;

  // expected correction for one frequency
  typedef struct {
    logic        ant;
    logic [2:0]  freq;
    logic [31:0] corr;
    logic        last;
  } corr_t;

  // tracks tables and registers, predicts corrections and checks them
  class correction_scoreboard;
    longint ofs_tab [2*NF*3];
    longint var_tab [2*NF*GP];
    bit     enable;
    longint delta [2][3];
    corr_t  pending [$];
    int     mismatches;

    function longint round_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return v < 0 ? -m : m;
    endfunction

    function longint sin_q(longint r);
      longint one, x, x2, s;
      one = 64'sd1 <<< 30;
      x = (r * 64'sd1686629713) >>> 14;
      x2 = (x * x) >>> 30;
      s = one - x2 / 110;
      s = one - ((x2 * s) >>> 30) / 72;
      s = one - ((x2 * s) >>> 30) / 42;
      s = one - ((x2 * s) >>> 30) / 20;
      s = one - ((x2 * s) >>> 30) / 6;
      s = (x * s) >>> 30;
      if (s > one) s = one;
      return s;
    endfunction

    function longint sine(logic [15:0] a);
      longint v;
      v = a[14] ? sin_q(16384 - a[13:0]) : sin_q(a[13:0]);
      return a[15] ? -v : v;
    endfunction

    function longint variation(int base, longint z);
      longint p, i, f;
      if (z < 0) return var_tab[base];
      p = z * 72;
      i = p >>> 16;
      if (i >= GP - 1) return var_tab[base + GP - 1];
      f = p & 16'hffff;
      return var_tab[base + i] + round_shift((var_tab[base + i + 1] - var_tab[base + i]) * f, 16);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      if (idx == CFG_MODEL_ENABLE) enable = d[0];
      else delta[(int'(idx) - 1) / 3][(int'(idx) - 1) % 3] = longint'($signed(d));
    endfunction

    function void note_input(logic [1:0] mode, logic ant, logic [2:0] fi, logic [4:0] ei,
                             logic [31:0] val, logic [15:0] az, logic [15:0] el);
      longint cel, e[3], acc, off;
      corr_t c;
      if (mode == MODE_LOAD_OFS) begin
        if (fi < NF && ei < 3) ofs_tab[(ant * NF + fi) * 3 + ei] = longint'($signed(val));
      end else if (mode == MODE_LOAD_VAR) begin
        if (fi < NF && ei < GP) var_tab[(ant * NF + fi) * GP + ei] = longint'($signed(val));
      end else if (mode == MODE_COMPUTE) begin
        cel = sine(el + 16'd16384);
        e[0] = round_shift(sine(az) * cel, 30);
        e[1] = round_shift(sine(az + 16'd16384) * cel, 30);
        e[2] = sine(el);
        for (int n = 0; n < NF; n++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) begin
            off = delta[ant][j];
            if (enable) off += ofs_tab[(ant * NF + n) * 3 + j];
            acc += round_shift(off * e[j], 30);
          end
          acc = -acc;
          if (enable) acc += variation((ant * NF + n) * GP, 16384 - longint'($signed(el)));
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          c.ant = ant; c.freq = 3'(n); c.corr = acc[31:0]; c.last = (n == NF - 1);
          pending.push_back(c);
        end
      end
    endfunction

    function void check_result(logic ant, logic [2:0] fq, logic [31:0] corr, logic last);
      corr_t c;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected correction ant=%0d freq=%0d", ant, fq);
        return;
      end
      c = pending.pop_front();
      if (c.ant !== ant || c.freq !== fq || c.corr !== corr || c.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ant=%0d freq=%0d corr=%0d last=%0d, got %0d %0d %0d %0d",
                   c.ant, c.freq, $signed(c.corr), c.last, ant, fq, $signed(corr), last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_antenna;
  logic [1:0] in_mode;
  logic [2:0] in_freq_index;
  logic [4:0] in_entry_index;
  logic signed [31:0] in_table_value;
  logic [15:0] in_azimuth;
  logic signed [15:0] in_elevation;
  logic out_valid, out_stall, out_antenna_out, out_last;
  logic [2:0] out_freq_out;
  logic signed [31:0] out_correction;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  correction_scoreboard sb;
  longint cycles;

  receiver_antenna_phase_correction_unit #(.NUM_FREQS(NF), .GRID_POINTS(GP)) DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check and random stall
  int stall_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_antenna_out, out_freq_out, out_correction, out_last);
      if (out_valid && !out_stall || stall_left == 0) begin
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 4) == 0) stall_left = 0;
      end else stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // valid stays up after an accepted transaction until the next gap or drain drops it
  task automatic send(logic [1:0] mode, logic ant, logic [2:0] fi, logic [4:0] ei,
                      logic [31:0] val, logic [15:0] az, logic [15:0] el);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_mode <= mode; in_antenna <= ant; in_freq_index <= fi;
    in_entry_index <= ei; in_table_value <= val; in_azimuth <= az; in_elevation <= el;
    do @(posedge clk); while (in_stall);
    sb.note_input(mode, ant, fi, ei, val, az, el);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic logic [15:0] rnd_el();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // fill every table entry so no later compute reads an unwritten entry
  task automatic load_tables();
    for (int a = 0; a < 2; a++)
      for (int f = 0; f < NF; f++) begin
        for (int k = 0; k < 3; k++)
          send(MODE_LOAD_OFS, 1'(a), 3'(f), 5'(k), rnd_word(), 16'($urandom()),
               16'($urandom()));
        for (int k = 0; k < GP; k++)
          send(MODE_LOAD_VAR, 1'(a), 3'(f), 5'(k), rnd_word(), 16'($urandom()),
               16'($urandom()));
      end
  endtask

  task automatic rand_item();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      send(MODE_COMPUTE, 1'($urandom()), 3'($urandom()), 5'($urandom()), $urandom(),
           16'($urandom()), rnd_el());
    else if (r == 6)
      send(MODE_LOAD_OFS, 1'($urandom()), 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
           rnd_word(), 16'($urandom()), 16'($urandom()));
    else if (r == 7)
      send(MODE_LOAD_VAR, 1'($urandom()), 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
           rnd_word(), 16'($urandom()), 16'($urandom()));
    else
      send(MODE_NONE, 1'($urandom()), 3'($urandom()), 5'($urandom()), $urandom(),
           16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    logic [31:0] ext [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    sb = new();
    cycles = 0; stall_left = 0;
    rst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0;
    in_mode = MODE_NONE; in_antenna = 0; in_freq_index = 0; in_entry_index = 0;
    in_table_value = 0; in_azimuth = 0; in_elevation = 0; cfg_index = 0; cfg_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // disabled model needs no tables
    send(MODE_COMPUTE, 0, 0, 0, 0, 16'h0000, 16'sd16384);
    drain();
    write_reg(CFG_ROVER_EAST, 32'h7fffffff);
    write_reg(CFG_BASE_UP, 32'h80000000);
    send(MODE_COMPUTE, 0, 7, 31, 32'hffffffff, 16'hffff, -16'sd16384);
    send(MODE_COMPUTE, 1, 0, 0, 0, 16'h4000, 16'sd0);
    load_tables();
    drain();
    write_reg(CFG_MODEL_ENABLE, 1);
    // directed: high/low zenith clamps, over-quarter elevation, ignored loads and mode 3
    send(MODE_COMPUTE, 0, 0, 0, 0, 16'h8000, 16'sd16384);
    send(MODE_COMPUTE, 1, 0, 0, 0, 16'hc000, 16'sd20000);
    send(MODE_COMPUTE, 1, 0, 0, 0, 16'h1234, -16'sd16384);
    send(MODE_COMPUTE, 0, 0, 0, 0, 16'h7fff, -16'sd32768);
    send(MODE_COMPUTE, 0, 0, 0, 0, 16'h2000, 16'sd1);
    send(MODE_LOAD_OFS, 0, 3'd7, 5'd0, 32'h12345678, 0, 0);
    send(MODE_LOAD_OFS, 0, 3'd0, 5'd3, 32'h12345678, 0, 0);
    send(MODE_LOAD_VAR, 1, 3'd0, 5'd19, 32'h12345678, 0, 0);
    send(MODE_LOAD_VAR, 1, 3'd0, 5'd31, 32'h12345678, 0, 0);
    send(MODE_NONE, 1, 3'd7, 5'd31, 32'hffffffff, 16'hffff, 16'hffff);
    send(MODE_COMPUTE, 1, 0, 0, 0, 16'h0001, 16'sd8192);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_MODEL_ENABLE, ph % 2 == 0);
      for (int k = 1; k <= 6; k++)
        write_reg(cfg_reg_t'(k), ph < 4 ? ext[(ph + k) % 4] : rnd_word());
      for (int i = 0; i < 80; i++) rand_item();
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
